/* rtl/tmr16_pkg.sv */
// Shared types, codes and decode functions for the 16-bit waveform timer.
package tmr16_pkg;

    // Item commands
    typedef enum logic [1:0] {
        CMD_TICK        = 2'd0,
        CMD_WRITE_COUNT = 2'd1,
        CMD_WRITE_FLAGS = 2'd2
    } cmd_t;

    // Configuration register indexes
    localparam logic [2:0] CFG_CLOCK_SELECT  = 3'd0;
    localparam logic [2:0] CFG_WAVEFORM_MODE = 3'd1;
    localparam logic [2:0] CFG_COMPARE_A     = 3'd2;
    localparam logic [2:0] CFG_COMPARE_B     = 3'd3;
    localparam logic [2:0] CFG_COMPARE_C     = 3'd4;
    localparam logic [2:0] CFG_CAPTURE_TOP   = 3'd5;
    localparam logic [2:0] CFG_POWER_OFF     = 3'd6;

    // Clock select codes
    typedef enum logic [2:0] {
        CS_STOP    = 3'd0,
        CS_DIV1    = 3'd1,
        CS_DIV8    = 3'd2,
        CS_DIV64   = 3'd3,
        CS_DIV256  = 3'd4,
        CS_DIV1024 = 3'd5,
        CS_EXT_FALL = 3'd6,
        CS_EXT_RISE = 3'd7
    } cs_t;

    // Waveform generation modes
    typedef enum logic [3:0] {
        WGM_NORMAL        = 4'd0,
        WGM_PC_8BIT       = 4'd1,
        WGM_PC_9BIT       = 4'd2,
        WGM_PC_10BIT      = 4'd3,
        WGM_CTC_OCRA      = 4'd4,
        WGM_FAST_8BIT     = 4'd5,
        WGM_FAST_9BIT     = 4'd6,
        WGM_FAST_10BIT    = 4'd7,
        WGM_PFC_ICR       = 4'd8,
        WGM_PFC_OCRA      = 4'd9,
        WGM_PC_ICR        = 4'd10,
        WGM_PC_OCRA       = 4'd11,
        WGM_CTC_ICR       = 4'd12,
        WGM_RESERVED      = 4'd13,
        WGM_FAST_ICR      = 4'd14,
        WGM_FAST_OCRA     = 4'd15
    } wgm_t;

    // Where TOP comes from
    typedef enum logic [2:0] {
        TOP_MAX,
        TOP_8BIT,
        TOP_9BIT,
        TOP_10BIT,
        TOP_OCRA,
        TOP_ICR
    } top_src_t;

    localparam logic [15:0] TOP_VAL_MAX   = 16'hffff;
    localparam logic [15:0] TOP_VAL_8BIT  = 16'h00ff;
    localparam logic [15:0] TOP_VAL_9BIT  = 16'h01ff;
    localparam logic [15:0] TOP_VAL_10BIT = 16'h03ff;

    // Result of one counter step
    typedef struct packed {
        logic [15:0] count;
        logic        down;
        logic [3:0]  flag_set;
    } step_t;

    function automatic logic is_dual(input wgm_t mode);
        logic dual;
        case (mode)
            WGM_PC_8BIT, WGM_PC_9BIT, WGM_PC_10BIT,
            WGM_PFC_ICR, WGM_PFC_OCRA, WGM_PC_ICR, WGM_PC_OCRA: dual = 1'b1;
            default: dual = 1'b0;
        endcase
        return dual;
    endfunction

    function automatic top_src_t top_src(input wgm_t mode);
        top_src_t src;
        case (mode)
            WGM_PC_8BIT, WGM_FAST_8BIT:                          src = TOP_8BIT;
            WGM_PC_9BIT, WGM_FAST_9BIT:                          src = TOP_9BIT;
            WGM_PC_10BIT, WGM_FAST_10BIT:                        src = TOP_10BIT;
            WGM_CTC_OCRA, WGM_PFC_OCRA, WGM_PC_OCRA, WGM_FAST_OCRA: src = TOP_OCRA;
            WGM_PFC_ICR, WGM_PC_ICR, WGM_CTC_ICR, WGM_FAST_ICR:  src = TOP_ICR;
            default:                                             src = TOP_MAX;
        endcase
        return src;
    endfunction

    // Timer runs only on an internal prescaled clock
    function automatic logic cs_running(input cs_t cs);
        logic run;
        case (cs)
            CS_DIV1, CS_DIV8, CS_DIV64, CS_DIV256, CS_DIV1024: run = 1'b1;
            default: run = 1'b0;
        endcase
        return run;
    endfunction

    // Last prescaler count before the counter advances (divider - 1)
    function automatic logic [9:0] prescale_last(input cs_t cs);
        logic [9:0] last;
        case (cs)
            CS_DIV8:    last = 10'd7;
            CS_DIV64:   last = 10'd63;
            CS_DIV256:  last = 10'd255;
            CS_DIV1024: last = 10'd1023;
            default:    last = 10'd0;
        endcase
        return last;
    endfunction

endpackage

/* rtl/tmr16_step.sv */
// One counter step: match flags, then count, wrap or reverse per waveform mode.
module tmr16_step (
    input  logic [15:0]         counter,
    input  logic                down,
    input  logic [3:0]          waveform_mode,
    input  logic [15:0]         compare_a,
    input  logic [15:0]         compare_b,
    input  logic [15:0]         compare_c,
    input  logic [15:0]         capture_top,
    output tmr16_pkg::step_t    step
);

    tmr16_pkg::wgm_t mode;
    logic            dual;
    logic [15:0]     top;
    logic [15:0]     ovf_point;
    logic [15:0]     count_inc;
    logic [15:0]     count_dec;

    assign mode      = tmr16_pkg::wgm_t'(waveform_mode);
    assign dual      = tmr16_pkg::is_dual(mode);
    assign ovf_point = dual ? 16'h0000 : tmr16_pkg::TOP_VAL_MAX;
    assign count_inc = counter + 16'd1;
    assign count_dec = counter - 16'd1;

    // TOP select
    always_comb
    begin
        case (tmr16_pkg::top_src(mode))
            tmr16_pkg::TOP_8BIT:  top = tmr16_pkg::TOP_VAL_8BIT;
            tmr16_pkg::TOP_9BIT:  top = tmr16_pkg::TOP_VAL_9BIT;
            tmr16_pkg::TOP_10BIT: top = tmr16_pkg::TOP_VAL_10BIT;
            tmr16_pkg::TOP_OCRA:  top = compare_a;
            tmr16_pkg::TOP_ICR:   top = capture_top;
            default:              top = tmr16_pkg::TOP_VAL_MAX;
        endcase
    end

    // Match flags on the value before the step, then next count and direction
    always_comb
    begin
        step.flag_set = {counter == compare_c, counter == compare_b,
                         counter == compare_a, counter == ovf_point};
        if (!dual)
        begin
            step.down  = 1'b0;
            step.count = (counter == top) ? 16'h0000 : count_inc;
        end
        else if (top == 16'h0000 && counter == 16'h0000)
        begin
            step.down  = 1'b0;
            step.count = counter;
        end
        else if (!down)
        begin
            step.down  = (counter == top);
            step.count = (counter == top) ? count_dec : count_inc;
        end
        else if (counter == 16'h0000)
        begin
            step.down  = 1'b0;
            step.count = 16'h0001;
        end
        else
        begin
            step.down  = 1'b1;
            step.count = count_dec;
        end
    end

endmodule

/* rtl/timer_16bit_waveform_counter.sv */
// Top level of the 16-bit timer/counter with prescaler and waveform modes.
//
// Input channel: in_valid / in_stall carry one item per cycle: command
// (tick, write counter, write flags) and write_value. Output channel:
// out_valid / out_stall carry one result per item: count and flags as they
// stand after that item. Items are accepted at an edge with valid high and
// stall low.
// The result of an item is registered and shown in the cycle after it is accepted.
// Throughput: one item per cycle while the receiver does not stall; the whole
// step is one pass of logic in front of the counter, prescaler and flag registers.
// When the receiver stalls, the pending result holds and in_stall rises in
// the same cycle, so no further item enters until the result is taken; the
// result is then replaced directly by the next one with no bubble.
// Configuration: cfg_write_en writes cfg_data into register cfg_index at
// the clock edge; write only while no result is pending. Index 7 is ignored.
// Reset: counter, prescaler, direction, flags and all registers go to zero,
// the output channel is empty and in_stall is low.
module timer_16bit_waveform_counter (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_write_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input items
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [15:0] write_value,
    // results
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] count,
    output logic [3:0]  flags
);

    logic [2:0]  clock_select_reg;
    logic [3:0]  waveform_mode_reg;
    logic [15:0] compare_a_reg;
    logic [15:0] compare_b_reg;
    logic [15:0] compare_c_reg;
    logic [15:0] capture_top_reg;
    logic        power_off_reg;

    logic [15:0] counter_reg,   counter_next;
    logic [9:0]  prescale_reg,  prescale_next;
    logic        down_reg,      down_next;
    logic [3:0]  flag_bits_reg, flag_bits_next;
    logic        out_valid_reg, out_valid_next;

    logic              in_accept;
    logic              running;
    tmr16_pkg::cs_t    cs;
    tmr16_pkg::step_t  step;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_select_reg  <= 3'd0;
            waveform_mode_reg <= 4'd0;
            compare_a_reg     <= 16'd0;
            compare_b_reg     <= 16'd0;
            compare_c_reg     <= 16'd0;
            capture_top_reg   <= 16'd0;
            power_off_reg     <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                tmr16_pkg::CFG_CLOCK_SELECT:  clock_select_reg  <= cfg_data[2:0];
                tmr16_pkg::CFG_WAVEFORM_MODE: waveform_mode_reg <= cfg_data[3:0];
                tmr16_pkg::CFG_COMPARE_A:     compare_a_reg     <= cfg_data;
                tmr16_pkg::CFG_COMPARE_B:     compare_b_reg     <= cfg_data;
                tmr16_pkg::CFG_COMPARE_C:     compare_c_reg     <= cfg_data;
                tmr16_pkg::CFG_CAPTURE_TOP:   capture_top_reg   <= cfg_data;
                tmr16_pkg::CFG_POWER_OFF:     power_off_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Handshake: the state registers double as the result register
    assign in_stall       = out_valid_reg & out_stall;
    assign in_accept      = in_valid & ~in_stall;
    assign out_valid_next = in_accept | (out_valid_reg & out_stall);

    assign cs      = tmr16_pkg::cs_t'(clock_select_reg);
    assign running = tmr16_pkg::cs_running(cs) & ~power_off_reg;

    tmr16_step u_step (
        .counter       (counter_reg),
        .down          (down_reg),
        .waveform_mode (waveform_mode_reg),
        .compare_a     (compare_a_reg),
        .compare_b     (compare_b_reg),
        .compare_c     (compare_c_reg),
        .capture_top   (capture_top_reg),
        .step          (step)
    );

    // Next state for the accepted item
    always_comb
    begin
        counter_next   = counter_reg;
        prescale_next  = prescale_reg;
        down_next      = down_reg;
        flag_bits_next = flag_bits_reg;
        if (in_accept)
        begin
            case (tmr16_pkg::cmd_t'(command))
                tmr16_pkg::CMD_TICK:
                begin
                    if (running)
                    begin
                        if (prescale_reg >= tmr16_pkg::prescale_last(cs))
                        begin
                            prescale_next  = 10'd0;
                            counter_next   = step.count;
                            down_next      = step.down;
                            flag_bits_next = flag_bits_reg | step.flag_set;
                        end
                        else
                        begin
                            prescale_next = prescale_reg + 10'd1;
                        end
                    end
                end
                tmr16_pkg::CMD_WRITE_COUNT: counter_next   = write_value;
                tmr16_pkg::CMD_WRITE_FLAGS: flag_bits_next = flag_bits_reg & ~write_value[3:0];
                default: ;
            endcase
        end
    end

    // State and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg   <= 16'd0;
            prescale_reg  <= 10'd0;
            down_reg      <= 1'b0;
            flag_bits_reg <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            counter_reg   <= counter_next;
            prescale_reg  <= prescale_next;
            down_reg      <= down_next;
            flag_bits_reg <= flag_bits_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign count     = counter_reg;
    assign flags     = flag_bits_reg;

endmodule

/* rtl/tmr16_checker.sv */
// Port-level checks for the 16-bit waveform timer, bound to the top level.
module tmr16_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  command,
    input logic [15:0] write_value,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] count,
    input logic [3:0]  flags
);

    logic in_accept;
    assign in_accept = in_valid & ~in_stall;

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(count) && $stable(flags))
        else $error("stalled result changed");

    // Every accepted item shows a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid)
        else $error("accepted item gave no result");

    // The input is never held off while the output side is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

    // A counter write shows up as the result count
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && command == tmr16_pkg::CMD_WRITE_COUNT |=> count == $past(write_value))
        else $error("counter write not reflected");

    // Flags written with one are cleared in the result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && command == tmr16_pkg::CMD_WRITE_FLAGS
        |=> (flags & $past(write_value[3:0])) == 4'd0)
        else $error("flag clear not applied");

endmodule

bind timer_16bit_waveform_counter tmr16_checker u_tmr16_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .write_value (write_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .count       (count),
    .flags       (flags)
);

/* sim/timer_16bit_waveform_counter_tb.sv */
// Self-checking testbench for the 16-bit waveform timer against a local timer model.
module timer_16bit_waveform_counter_tb;

    // Command code the block leaves unused
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Flag bit masks
    localparam logic [3:0] FLAG_OVF   = 4'b0001;
    localparam logic [3:0] FLAG_CMP_A = 4'b0010;
    localparam logic [3:0] FLAG_CMP_B = 4'b0100;
    localparam logic [3:0] FLAG_CMP_C = 4'b1000;

    localparam int NUM_PHASES     = 20;
    localparam int OPS_PER_PHASE  = 110;
    localparam int OPS_STOPPED    = 30;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 4;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int MAX_MSG_LINES  = 40;

    typedef struct {
        logic [1:0]  cmd;
        logic [15:0] value;
    } timer_op_t;

    typedef struct {
        logic [15:0] count;
        logic [3:0]  flags;
    } timer_reading_t;

    // DUT connections, all inputs known from time zero
    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_write_en = 1'b0;
    logic [2:0]  cfg_index    = '0;
    logic [15:0] cfg_data     = '0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic [1:0]  command      = '0;
    logic [15:0] write_value  = '0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [15:0] count;
    logic [3:0]  flags;

    // Timer model: registers and state
    tmr16_pkg::cs_t  model_cs        = tmr16_pkg::CS_STOP;
    tmr16_pkg::wgm_t model_mode      = tmr16_pkg::WGM_NORMAL;
    logic [15:0]     model_cmp_a     = '0;
    logic [15:0]     model_cmp_b     = '0;
    logic [15:0]     model_cmp_c     = '0;
    logic [15:0]     model_capture   = '0;
    logic            model_power_off = 1'b0;
    logic [15:0]     model_counter   = '0;
    logic [9:0]      model_prescale  = '0;
    logic            model_down      = 1'b0;
    logic [3:0]      model_flags     = '0;

    timer_op_t      pending_ops[$];
    timer_reading_t expected_readings[$];
    timer_op_t      offered_op;
    timer_reading_t accepted_reading;
    timer_reading_t want;

    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int hold_req_id    = 0;
    int hold_seen_id   = 0;
    int hold_left      = 0;
    int error_count    = 0;
    int cycle_count    = 0;

    timer_16bit_waveform_counter DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .write_value  (write_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .count        (count),
        .flags        (flags)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Timer model
    // ---------------------------------------------------------------
    function automatic int unsigned prescale_divider(input tmr16_pkg::cs_t cs);
        case (cs)
            tmr16_pkg::CS_DIV1:    return 1;
            tmr16_pkg::CS_DIV8:    return 8;
            tmr16_pkg::CS_DIV64:   return 64;
            tmr16_pkg::CS_DIV256:  return 256;
            tmr16_pkg::CS_DIV1024: return 1024;
            default:               return 0;
        endcase
    endfunction

    function automatic logic dual_slope(input tmr16_pkg::wgm_t mode);
        return (mode >= tmr16_pkg::WGM_PC_8BIT && mode <= tmr16_pkg::WGM_PC_10BIT) ||
               (mode >= tmr16_pkg::WGM_PFC_ICR && mode <= tmr16_pkg::WGM_PC_OCRA);
    endfunction

    function automatic logic [15:0] model_top();
        case (model_mode)
            tmr16_pkg::WGM_PC_8BIT, tmr16_pkg::WGM_FAST_8BIT:
                return tmr16_pkg::TOP_VAL_8BIT;
            tmr16_pkg::WGM_PC_9BIT, tmr16_pkg::WGM_FAST_9BIT:
                return tmr16_pkg::TOP_VAL_9BIT;
            tmr16_pkg::WGM_PC_10BIT, tmr16_pkg::WGM_FAST_10BIT:
                return tmr16_pkg::TOP_VAL_10BIT;
            tmr16_pkg::WGM_CTC_OCRA, tmr16_pkg::WGM_PFC_OCRA,
            tmr16_pkg::WGM_PC_OCRA, tmr16_pkg::WGM_FAST_OCRA:
                return model_cmp_a;
            tmr16_pkg::WGM_PFC_ICR, tmr16_pkg::WGM_PC_ICR,
            tmr16_pkg::WGM_CTC_ICR, tmr16_pkg::WGM_FAST_ICR:
                return model_capture;
            default:
                return tmr16_pkg::TOP_VAL_MAX;
        endcase
    endfunction

    // One counter step: flags from the old value, then count/wrap/reverse
    task automatic count_one_step();
        logic [15:0] t;
        logic [15:0] top;
        logic        dual;
        t    = model_counter;
        top  = model_top();
        dual = dual_slope(model_mode);
        if (t == (dual ? 16'h0000 : tmr16_pkg::TOP_VAL_MAX))
            model_flags |= FLAG_OVF;
        if (t == model_cmp_a)
            model_flags |= FLAG_CMP_A;
        if (t == model_cmp_b)
            model_flags |= FLAG_CMP_B;
        if (t == model_cmp_c)
            model_flags |= FLAG_CMP_C;
        if (!dual)
        begin
            model_down = 1'b0;
            t = (t == top) ? 16'h0000 : t + 16'd1;
        end
        else if (top == 16'h0000 && t == 16'h0000)
        begin
            // zero TOP pins the counter at BOTTOM
            model_down = 1'b0;
        end
        else if (!model_down)
        begin
            if (t == top)
            begin
                model_down = 1'b1;
                t = t - 16'd1;
            end
            else
                t = t + 16'd1;
        end
        else if (t == 16'h0000)
        begin
            model_down = 1'b0;
            t = 16'd1;
        end
        else
            t = t - 16'd1;
        model_counter = t;
    endtask

    task automatic predict_timer_op(input timer_op_t op, output timer_reading_t reading);
        int unsigned divider;
        int unsigned next_prescale;
        divider       = prescale_divider(model_cs);
        next_prescale = model_prescale + 1;
        case (op.cmd)
            tmr16_pkg::CMD_TICK:
            begin
                if (divider != 0 && !model_power_off)
                begin
                    if (next_prescale < divider)
                        model_prescale = model_prescale + 10'd1;
                    else
                    begin
                        model_prescale = '0;
                        count_one_step();
                    end
                end
            end
            tmr16_pkg::CMD_WRITE_COUNT: model_counter = op.value;
            tmr16_pkg::CMD_WRITE_FLAGS: model_flags &= ~op.value[3:0];
            default: ;
        endcase
        reading.count = model_counter;
        reading.flags = model_flags;
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] exp_val);
        error_count++;
        if (error_count <= MAX_MSG_LINES)
            $display("Mismatch at cycle %0d: %s got %h, expected %h",
                     cycle_count, what, got, exp_val);
    endtask

    // ---------------------------------------------------------------
    // Driver: offers queued items, predicts each accepted one
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            command     <= tmr16_pkg::CMD_TICK;
            write_value <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_timer_op(offered_op, accepted_reading);
                expected_readings.push_back(accepted_reading);
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_ops.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    offered_op = pending_ops.pop_front();
                    in_valid    <= 1'b1;
                    command     <= offered_op.cmd;
                    write_value <= offered_op.value;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus long hold-offs on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall    <= 1'b0;
            hold_left    <= 0;
            hold_seen_id <= 0;
        end
        else if (hold_seen_id != hold_req_id)
        begin
            hold_seen_id <= hold_req_id;
            hold_left    <= HOLD_CYCLES;
            out_stall    <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Monitor: compare every accepted result with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_readings.size() == 0)
                report_mismatch("unexpected result, count", count, 16'h0000);
            else
            begin
                want = expected_readings.pop_front();
                if (count !== want.count)
                    report_mismatch("count", count, want.count);
                if (flags !== want.flags)
                    report_mismatch("flags", {12'd0, flags}, {12'd0, want.flags});
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic queue_op(input logic [1:0] cmd, input logic [15:0] value);
        pending_ops.push_back('{cmd, value});
    endtask

    // Wait until every item is sent and every result taken
    task automatic drain();
        while (pending_ops.size() != 0 || in_valid || expected_readings.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [2:0] index, input logic [15:0] value);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= index;
        cfg_data     <= value;
        case (index)
            tmr16_pkg::CFG_CLOCK_SELECT:  model_cs        = tmr16_pkg::cs_t'(value[2:0]);
            tmr16_pkg::CFG_WAVEFORM_MODE: model_mode      = tmr16_pkg::wgm_t'(value[3:0]);
            tmr16_pkg::CFG_COMPARE_A:     model_cmp_a     = value;
            tmr16_pkg::CFG_COMPARE_B:     model_cmp_b     = value;
            tmr16_pkg::CFG_COMPARE_C:     model_cmp_c     = value;
            tmr16_pkg::CFG_CAPTURE_TOP:   model_capture   = value;
            tmr16_pkg::CFG_POWER_OFF:     model_power_off = value[0];
            default: ;
        endcase
    endtask

    // Write all registers while idle, then return at a falling edge
    task automatic set_timer(input tmr16_pkg::cs_t cs, input tmr16_pkg::wgm_t mode,
                             input logic [15:0] cmp_a,
                             input logic [15:0] cmp_b, input logic [15:0] cmp_c,
                             input logic [15:0] capture, input logic power_off);
        write_register(tmr16_pkg::CFG_CLOCK_SELECT, {13'd0, cs});
        write_register(tmr16_pkg::CFG_WAVEFORM_MODE, {12'd0, mode});
        write_register(tmr16_pkg::CFG_COMPARE_A, cmp_a);
        write_register(tmr16_pkg::CFG_COMPARE_B, cmp_b);
        write_register(tmr16_pkg::CFG_COMPARE_C, cmp_c);
        write_register(tmr16_pkg::CFG_CAPTURE_TOP, capture);
        write_register(tmr16_pkg::CFG_POWER_OFF, {15'd0, power_off});
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(negedge clk);
    endtask

    // Counter values that land near TOP, BOTTOM, compare points or above TOP
    function automatic logic [15:0] pick_count_value();
        logic [15:0] top;
        top = model_top();
        case ($urandom_range(5))
            0:       return top - 16'($urandom_range(3));
            1:       return 16'($urandom_range(3));
            2:       return model_cmp_b - 16'($urandom_range(2));
            3:       return model_cmp_c - 16'($urandom_range(2));
            4:       return top + 16'($urandom_range(1, 3));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_random_ops(input int n);
        int useful;
        int pick;
        useful = 0;
        while (useful < n)
        begin
            pick = $urandom_range(99);
            if (pick < 84)
                queue_op(tmr16_pkg::CMD_TICK, 16'($urandom));
            else if (pick < 92)
                queue_op(tmr16_pkg::CMD_WRITE_COUNT, pick_count_value());
            else if (pick < 98)
                queue_op(tmr16_pkg::CMD_WRITE_FLAGS, 16'($urandom));
            else
                queue_op(CMD_UNUSED, 16'($urandom));
            if (pick < 98)
                useful++;
        end
    endtask

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial
    begin
        int             phase;
        tmr16_pkg::cs_t cs;
        logic [15:0]    cmp_a;
        logic [15:0]    cmp_b;
        logic [15:0]    cmp_c;
        logic [15:0]    capture;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Stopped after reset: ticks do nothing, writes still work
        send_gap_pct   = 10;
        recv_stall_pct = 62;
        queue_op(tmr16_pkg::CMD_TICK, 16'h0000);
        queue_op(tmr16_pkg::CMD_WRITE_COUNT, 16'hffff);
        queue_op(tmr16_pkg::CMD_TICK, 16'hffff);
        queue_op(CMD_UNUSED, 16'hffff);
        queue_op(tmr16_pkg::CMD_WRITE_FLAGS, 16'hffff);
        drain();

        // Single slope: overflow and compare hits, wrap past 0xffff, flag clears
        set_timer(tmr16_pkg::CS_DIV1, tmr16_pkg::WGM_NORMAL,
                  16'hffff, 16'h0000, 16'h0001, 16'h0000, 1'b0);
        queue_op(tmr16_pkg::CMD_TICK, 16'h0000);
        queue_op(tmr16_pkg::CMD_TICK, 16'h0000);
        queue_op(tmr16_pkg::CMD_TICK, 16'h0000);
        queue_op(tmr16_pkg::CMD_WRITE_FLAGS, 16'hfff0);
        queue_op(tmr16_pkg::CMD_WRITE_FLAGS, 16'h0005);
        queue_op(tmr16_pkg::CMD_WRITE_COUNT, 16'h0000);
        drain();

        // Dual slope with zero TOP: counter stays at zero
        set_timer(tmr16_pkg::CS_DIV1, tmr16_pkg::WGM_PC_ICR,
                  16'hffff, 16'h0000, 16'hffff, 16'h0000, 1'b0);
        queue_op(tmr16_pkg::CMD_TICK, 16'h0000);
        queue_op(tmr16_pkg::CMD_TICK, 16'h0000);
        drain();

        // Dual slope 8-bit: reverse at TOP and BOTTOM, above TOP keeps counting up
        set_timer(tmr16_pkg::CS_DIV1, tmr16_pkg::WGM_PC_8BIT,
                  16'h00ff, 16'h00fe, 16'h0001, 16'hffff, 1'b0);
        queue_op(tmr16_pkg::CMD_WRITE_COUNT, 16'h00fe);
        queue_op(tmr16_pkg::CMD_TICK, 16'h0000);
        queue_op(tmr16_pkg::CMD_TICK, 16'h0000);
        queue_op(tmr16_pkg::CMD_WRITE_COUNT, 16'h0001);
        queue_op(tmr16_pkg::CMD_TICK, 16'h0000);
        queue_op(tmr16_pkg::CMD_TICK, 16'h0000);
        queue_op(tmr16_pkg::CMD_WRITE_COUNT, 16'h1000);
        queue_op(tmr16_pkg::CMD_TICK, 16'h0000);
        drain();

        // Powered down: tick changes nothing
        set_timer(tmr16_pkg::CS_DIV1, tmr16_pkg::WGM_NORMAL,
                  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
        queue_op(tmr16_pkg::CMD_TICK, 16'h0000);
        queue_op(tmr16_pkg::CMD_WRITE_FLAGS, 16'h000f);
        drain();

        // Random phases over every mode and clock select
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase < 7)
            begin
                send_gap_pct   = 10;
                recv_stall_pct = 62;
            end
            else if (phase < 14)
            begin
                send_gap_pct   = 62;
                recv_stall_pct = 10;
            end
            else
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end

            // prescale 1024 followed by 8 leaves the prescaler beyond the new divider
            case (phase)
                3:       cs = tmr16_pkg::CS_DIV8;
                5:       cs = tmr16_pkg::CS_DIV64;
                7:       cs = tmr16_pkg::CS_DIV256;
                8:       cs = tmr16_pkg::CS_DIV1024;
                9:       cs = tmr16_pkg::CS_DIV8;
                16:      cs = tmr16_pkg::CS_STOP;
                17:      cs = tmr16_pkg::CS_EXT_FALL;
                18:      cs = tmr16_pkg::CS_EXT_RISE;
                default: cs = tmr16_pkg::CS_DIV1;
            endcase
            cmp_a   = (phase % 5 == 4) ? 16'h0000 :
                      (phase == 10) ? 16'hffff : 16'($urandom_range(2, 40));
            cmp_b   = (phase == 0) ? 16'hffff : 16'($urandom_range(0, 48));
            cmp_c   = (phase == 1) ? 16'hffff :
                      (phase % 3 == 0) ? 16'($urandom) : 16'($urandom_range(0, 48));
            capture = (phase == 10) ? 16'h0000 :
                      (phase == 14) ? 16'hffff : 16'($urandom_range(2, 40));
            set_timer(cs, tmr16_pkg::wgm_t'(phase % 16), cmp_a, cmp_b, cmp_c, capture,
                      phase == 19);

            if (phase >= 16 && phase <= 18)
                queue_random_ops(OPS_STOPPED);
            else if (phase == 11)
            begin
                // sender pauses mid-phase until every result is back
                queue_random_ops(OPS_PER_PHASE / 2);
                drain();
                queue_random_ops(OPS_PER_PHASE / 2);
            end
            else
                queue_random_ops(OPS_PER_PHASE);

            // long receiver hold-off while items keep coming
            if (phase == 4)
                hold_req_id++;
            drain();
        end

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
